@@ hdl/sdd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sdd_pkg
// Shared types and constants for the SSE data line deframer.
// ---------------------------------------------------------------------------
package sdd_pkg;

  localparam int OUT_W = 32;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  // Work for one accepted byte: up to a payload byte, a newline and a close.
  typedef struct packed {
    logic       pay_en;
    logic [7:0] pay_val;
    logic       nl_en;
    logic       close_en;
  } sdd_op_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0: c = 8'h64;  // d
      3'd1: c = 8'h61;  // a
      3'd2: c = 8'h74;  // t
      3'd3: c = 8'h61;  // a
      3'd4: c = 8'h3A;  // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ hdl/sse_data_line_deframer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sse_data_line_deframer
// Extracts "data:" line payload from an SSE body and reports event closes.
// A byte's results are queued, then registered. One byte per cycle is taken
// while the queue has room; the result sequencer sends a byte's k results
// one per cycle out of its register unless out_ready is low. A 4-entry
// queue absorbs these bursts. Reset is synchronous, active low; it clears
// line state and counts and leaves the parser enabled.
// ---------------------------------------------------------------------------
module sse_data_line_deframer
  import sdd_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_body_byte,
  input  wire logic             in_end_of_body,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_parser_enabled,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_result_kind,
  output logic [7:0]            out_payload_value,
  output logic [OUT_W-1:0]      out_closed_event_length,
  output logic [OUT_W-1:0]      out_events_seen,
  output logic [OUT_W-1:0]      out_payload_total,
  output logic                  out_run_last
);

  localparam int QW = $bits(sdd_op_t) + COUNT_BITS;

  logic                  q_full, q_empty, q_push, q_pop;
  sdd_op_t               push_op, head_op;
  logic [COUNT_BITS-1:0] push_len, head_len;
  logic [QW-1:0]         head_data;

  sdd_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_body_byte       (in_body_byte),
    .in_end_of_body     (in_end_of_body),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_parser_enabled (cfg_parser_enabled),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_op               (push_op),
    .q_len              (push_len)
  );

  sdd_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_op, push_len}),
    .pop       (q_pop),
    .head_data (head_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign head_op  = head_data[QW-1:COUNT_BITS];
  assign head_len = head_data[COUNT_BITS-1:0];

  sdd_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .head_op                 (head_op),
    .head_len                (head_len),
    .q_empty                 (q_empty),
    .q_pop                   (q_pop),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_result_kind         (out_result_kind),
    .out_payload_value       (out_payload_value),
    .out_closed_event_length (out_closed_event_length),
    .out_events_seen         (out_events_seen),
    .out_payload_total       (out_payload_total),
    .out_run_last            (out_run_last)
  );

endmodule
`default_nettype wire

@@ hdl/sdd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sdd_front
// Line scanner: classifies each body byte and queues the work it causes.
// ---------------------------------------------------------------------------
module sdd_front
  import sdd_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_body_byte,
  input  wire logic                  in_end_of_body,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_parser_enabled,
  input  wire logic                  q_full,
  output logic                       q_push,
  output sdd_op_t                    q_op,
  output logic [COUNT_BITS-1:0]      q_len
);

  localparam int SUM_W = COUNT_BITS + 1;

  typedef enum logic [3:0] {
    PH_START       = 4'd0,
    PH_D1          = 4'd1,
    PH_D2          = 4'd2,
    PH_D3          = 4'd3,
    PH_D4          = 4'd4,
    PH_PREFIX_DONE = 4'd5,
    PH_PAYLOAD     = 4'd6,
    PH_SKIP        = 4'd7,
    PH_AFTER_CR    = 4'd8,
    PH_AFTER_LF    = 4'd9
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic                  lhp_r, lhp_nxt, lhp_mid;
  logic [COUNT_BITS-1:0] len_r, len_nxt, len_after;
  logic [SUM_W-1:0]      len_sum;
  logic                  enabled_r;

  logic       accept, take;
  logic       is_cr, is_lf, is_break, paired, line_start;
  logic       pay_en, nl_en, close_brk, close_cond, close_en;
  logic [7:0] pay_val;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign take      = accept && enabled_r;

  assign is_cr      = (in_body_byte == CH_CR);
  assign is_lf      = (in_body_byte == CH_LF);
  assign is_break   = is_cr || is_lf;
  assign paired     = ((phase_r == PH_AFTER_CR) && is_lf) ||
                      ((phase_r == PH_AFTER_LF) && is_cr);
  assign line_start = (phase_r == PH_START) || (phase_r == PH_AFTER_CR) ||
                      (phase_r == PH_AFTER_LF);

  always_comb begin
    phase_nxt = phase_r;
    lhp_mid   = lhp_r;
    pay_en    = 1'b0;
    pay_val   = in_body_byte;
    close_brk = 1'b0;
    if (is_break) begin
      if (paired) begin
        phase_nxt = PH_START;
      end else begin
        if (line_start) begin
          close_brk = 1'b1;
        end else if (((phase_r == PH_PREFIX_DONE) || (phase_r == PH_PAYLOAD)) && lhp_r) begin
          pay_en  = 1'b1;
          pay_val = CH_LF;
        end
        phase_nxt = is_cr ? PH_AFTER_CR : PH_AFTER_LF;
        lhp_mid   = 1'b0;
      end
    end else begin
      unique case (phase_r) inside
        PH_D1, PH_D2, PH_D3, PH_D4: begin
          phase_nxt = (in_body_byte == prefix_char(phase_r[2:0])) ?
                      phase_t'(phase_r + 4'd1) : PH_SKIP;
        end
        PH_PREFIX_DONE: begin
          if (in_body_byte != CH_SPACE) begin
            pay_en  = 1'b1;
            lhp_mid = 1'b1;
          end
          phase_nxt = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          pay_en  = 1'b1;
          lhp_mid = 1'b1;
        end
        PH_SKIP: begin
          phase_nxt = PH_SKIP;
        end
        default: begin
          phase_nxt = (in_body_byte == prefix_char(3'd0)) ? PH_D1 : PH_SKIP;
          lhp_mid   = 1'b0;
        end
      endcase
    end

    nl_en      = in_end_of_body && !is_break && lhp_mid;
    close_cond = close_brk || in_end_of_body;
    len_sum    = {1'b0, len_r} + SUM_W'(pay_en) + SUM_W'(nl_en);
    len_after  = len_sum[COUNT_BITS] ? '1 : len_sum[COUNT_BITS-1:0];
    close_en   = close_cond && (len_after != '0);
    len_nxt    = close_cond ? '0 : len_after;
    lhp_nxt    = lhp_mid;
    if (in_end_of_body) begin
      phase_nxt = PH_START;
      lhp_nxt   = 1'b0;
    end
  end

  assign q_push         = take && (pay_en || nl_en || close_en);
  assign q_op.pay_en    = pay_en;
  assign q_op.pay_val   = pay_val;
  assign q_op.nl_en     = nl_en;
  assign q_op.close_en  = close_en;
  assign q_len          = len_after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      lhp_r     <= 1'b0;
      len_r     <= '0;
      enabled_r <= 1'b1;
    end else begin
      if (cfg_valid) begin
        enabled_r <= cfg_parser_enabled;
      end
      if (take) begin
        phase_r <= phase_nxt;
        lhp_r   <= lhp_nxt;
        len_r   <= len_nxt;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/sdd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sdd_queue
// Short FIFO that decouples the line scanner from the result sequencer.
// ---------------------------------------------------------------------------
module sdd_queue
  import sdd_pkg::*;
#(
  parameter int W = 43
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic [W-1:0]      head_data,
  output logic              full,
  output logic              empty
);

  logic [W-1:0]      mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r;

  assign full      = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty     = (cnt_r == '0);
  assign head_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/sdd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sdd_back
// Result sequencer: expands queued work into results, keeps event counts.
// ---------------------------------------------------------------------------
module sdd_back
  import sdd_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire sdd_op_t               head_op,
  input  wire logic [COUNT_BITS-1:0] head_len,
  input  wire logic                  q_empty,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_result_kind,
  output logic [7:0]                 out_payload_value,
  output logic [OUT_W-1:0]           out_closed_event_length,
  output logic [OUT_W-1:0]           out_events_seen,
  output logic [OUT_W-1:0]           out_payload_total,
  output logic                       out_run_last
);

  localparam int SUM_W = COUNT_BITS + 1;

  logic                  out_valid_r;
  logic [2:0]            done_r;
  logic [COUNT_BITS-1:0] ev_r, tot_r, ev_inc, tot_inc;
  logic [SUM_W-1:0]      ev_sum, tot_sum;
  logic [2:0]            flags, pending, sel, rest;
  logic                  load;

  logic                  kind_r, last_r;
  logic [7:0]            val_r;
  logic [OUT_W-1:0]      clen_r, evs_r, tots_r;

  assign flags   = {head_op.close_en, head_op.nl_en, head_op.pay_en};
  assign pending = flags & ~done_r;
  assign sel     = pending & (~pending + 3'd1);
  assign rest    = pending & ~sel;
  assign load    = !q_empty && (!out_valid_r || out_ready);
  assign q_pop   = load && (rest == '0);

  assign ev_sum  = {1'b0, ev_r} + SUM_W'(1);
  assign tot_sum = {1'b0, tot_r} + {1'b0, head_len};
  assign ev_inc  = ev_sum[COUNT_BITS] ? '1 : ev_sum[COUNT_BITS-1:0];
  assign tot_inc = tot_sum[COUNT_BITS] ? '1 : tot_sum[COUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_r      <= '0;
      ev_r        <= '0;
      tot_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        done_r      <= (rest == '0) ? 3'b000 : (done_r | sel);
        if (sel[2]) begin
          ev_r  <= ev_inc;
          tot_r <= tot_inc;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= sel[2] ? KIND_EVENT : KIND_PAYLOAD;
      val_r  <= sel[0] ? head_op.pay_val : (sel[1] ? CH_LF : 8'h00);
      clen_r <= sel[2] ? OUT_W'(head_len) : '0;
      evs_r  <= sel[2] ? OUT_W'(ev_inc) : OUT_W'(ev_r);
      tots_r <= sel[2] ? OUT_W'(tot_inc) : OUT_W'(tot_r);
      last_r <= (rest == '0);
    end
  end

  assign out_valid               = out_valid_r;
  assign out_result_kind         = kind_r;
  assign out_payload_value       = val_r;
  assign out_closed_event_length = clen_r;
  assign out_events_seen         = evs_r;
  assign out_payload_total       = tots_r;
  assign out_run_last            = last_r;

endmodule
`default_nettype wire
